FILE: rtl/core/conv2d_3x3_valid_defines.svh
// Assertion macros used by the checker module.
// Each one samples on clk and is switched off while arst_n is low.
`ifndef CONV2D_3X3_VALID_DEFINES_SVH
`define CONV2D_3X3_VALID_DEFINES_SVH

// The consequence must hold in the cycle after the antecedent ends.
`define C2D_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// The consequence must hold in the cycle where the antecedent ends.
`define C2D_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/c2d_pkg.sv
package c2d_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_PIXEL_BITS = 16;

	localparam int COEF_BITS    = 16;
	localparam int KERNEL_TAPS  = 3;
	localparam int SUM_BITS     = 36;
	localparam int HEIGHT_LIMIT = 1024;
	localparam int ROW_BITS     = $clog2(HEIGHT_LIMIT);
	localparam int MIN_DIM      = 3;
	// first row and column at which the window covers the image
	localparam int EDGE_SKIP    = 2;

	localparam int KROW_BITS     = 48;
	localparam int DIM_BITS      = 11;
	localparam int CFG_DATA_BITS = 64;
	localparam int CFG_ADDR_BITS = 6;
	localparam int REG_IDX_BITS  = 3;

	localparam int OUT_FIFO_DEPTH = 8;

	typedef logic [REG_IDX_BITS-1:0] reg_idx_t;
	typedef logic signed [COEF_BITS-1:0] coef_t;

	localparam reg_idx_t REG_KTOP   = 3'd0;
	localparam reg_idx_t REG_KMID   = 3'd1;
	localparam reg_idx_t REG_KBOT   = 3'd2;
	localparam reg_idx_t REG_WIDTH  = 3'd3;
	localparam reg_idx_t REG_HEIGHT = 3'd4;

	function automatic coef_t coef_at(input logic [KROW_BITS-1:0] krow, input int col);
		coef_t c;
		c = krow[COEF_BITS*col +: COEF_BITS];
		return c;
	endfunction

endpackage

FILE: rtl/core/c2d_ram.sv
module c2d_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/core/conv2d_3x3_valid.sv
// Channel   | Direction | Transaction                   | Payload
// ----------+-----------+-------------------------------+---------------------------
// pixel in  | in        | in_valid && in_ready          | pixel_value
// result    | out       | out_valid && out_ready        | conv_sum, frame_end
// config    | in        | psel && penable && pwrite     | paddr, pwdata (prdata back)
//
// One pixel per cycle while in_ready is high; a result passes the pipeline below, then the FIFO.
// Pipeline: line RAM read, window shift and line write, 9 multiplies, row sums, final sum.
// Results queue in an 8-entry output FIFO; in_ready drops once 8 results are pending.
// Reset clears counters, pipeline valids, FIFO and kernel; line RAM needs no clearing.
// A stalled output does not stall the pixel side until the FIFO credit runs out.
module conv2d_3x3_valid #(
	parameter int MAX_WIDTH  = c2d_pkg::DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = c2d_pkg::DEF_PIXEL_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [c2d_pkg::CFG_ADDR_BITS-1:0]    paddr,
	input  logic [c2d_pkg::CFG_DATA_BITS-1:0]    pwdata,
	output logic [c2d_pkg::CFG_DATA_BITS-1:0]    prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [PIXEL_BITS-1:0]         pixel_value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [c2d_pkg::SUM_BITS-1:0]  conv_sum,
	output logic                                 frame_end
);

	import c2d_pkg::*;

	localparam int CW        = $clog2(MAX_WIDTH);
	localparam int WW        = $clog2(MAX_WIDTH + 1);
	localparam int CMPW      = (WW > DIM_BITS) ? WW : DIM_BITS;
	localparam int PROD_BITS = PIXEL_BITS + COEF_BITS;
	localparam int RSUM_BITS = PROD_BITS + 2;
	localparam int ACC_BITS  = PROD_BITS + 4;
	localparam int FIFO_AW   = $clog2(OUT_FIFO_DEPTH);
	localparam int CNT_BITS  = FIFO_AW + 1;

	// configuration registers
	logic [KROW_BITS-1:0] krow_q [KERNEL_TAPS];
	logic [DIM_BITS-1:0]  width_q;
	logic [DIM_BITS-1:0]  height_q;

	reg_idx_t cfg_idx;
	logic     cfg_wr;
	logic     geo_wr;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[CFG_ADDR_BITS-1:CFG_ADDR_BITS-REG_IDX_BITS];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign geo_wr  = cfg_wr && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KERNEL_TAPS; i++) krow_q[i] <= '0;
			width_q  <= DIM_BITS'(DEF_MAX_WIDTH);
			height_q <= DIM_BITS'(HEIGHT_LIMIT);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_KTOP:   krow_q[0] <= pwdata[KROW_BITS-1:0];
				REG_KMID:   krow_q[1] <= pwdata[KROW_BITS-1:0];
				REG_KBOT:   krow_q[2] <= pwdata[KROW_BITS-1:0];
				REG_WIDTH:  width_q   <= pwdata[DIM_BITS-1:0];
				REG_HEIGHT: height_q  <= pwdata[DIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_KTOP:   prdata = CFG_DATA_BITS'(krow_q[0]);
			REG_KMID:   prdata = CFG_DATA_BITS'(krow_q[1]);
			REG_KBOT:   prdata = CFG_DATA_BITS'(krow_q[2]);
			REG_WIDTH:  prdata = CFG_DATA_BITS'(width_q);
			REG_HEIGHT: prdata = CFG_DATA_BITS'(height_q);
			default:    prdata = '0;
		endcase
	end

	// clamp geometry to the supported range
	logic [CMPW-1:0]     width_ext;
	logic [CMPW-1:0]     width_act;
	logic [DIM_BITS-1:0] height_act;
	logic [CW-1:0]       last_col;
	logic [ROW_BITS-1:0] last_row;

	assign width_ext = CMPW'(width_q);

	always_comb begin
		priority if (width_ext < CMPW'(MIN_DIM)) begin
			width_act = CMPW'(MIN_DIM);
		end else if (width_ext > CMPW'(MAX_WIDTH)) begin
			width_act = CMPW'(MAX_WIDTH);
		end else begin
			width_act = width_ext;
		end
		priority if (height_q < DIM_BITS'(MIN_DIM)) begin
			height_act = DIM_BITS'(MIN_DIM);
		end else if (height_q > DIM_BITS'(HEIGHT_LIMIT)) begin
			height_act = DIM_BITS'(HEIGHT_LIMIT);
		end else begin
			height_act = height_q;
		end
	end

	assign last_col = CW'(width_act - CMPW'(1));
	assign last_row = ROW_BITS'(height_act - DIM_BITS'(1));

	// raster position of the next pixel
	logic [CW-1:0]       col_q;
	logic [ROW_BITS-1:0] row_q;
	logic                accept;
	logic                emit_now;
	logic                last_now;
	logic [CNT_BITS-1:0] pend_q;
	logic                pop;

	assign in_ready = pend_q < CNT_BITS'(OUT_FIFO_DEPTH);
	assign accept   = in_valid && in_ready;
	assign emit_now = (row_q >= ROW_BITS'(EDGE_SKIP)) && (col_q >= CW'(EDGE_SKIP));
	assign last_now = (row_q == last_row) && (col_q == last_col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (geo_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_q == last_col) begin
				col_q <= '0;
				row_q <= (row_q == last_row) ? '0 : row_q + ROW_BITS'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// count results owed: taken pixels that emit, not yet popped from the FIFO
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			unique case ({accept && emit_now, pop})
				2'b10:   pend_q <= pend_q + CNT_BITS'(1);
				2'b01:   pend_q <= pend_q - CNT_BITS'(1);
				default: pend_q <= pend_q;
			endcase
		end
	end

	// stage 1: line RAM read data arrives
	logic                         valid_s1;
	logic                         emit_s1;
	logic                         last_s1;
	logic signed [PIXEL_BITS-1:0] pix_s1;
	logic [CW-1:0]                addr_s1;
	logic [2*PIXEL_BITS-1:0]      line_rd;
	logic signed [PIXEL_BITS-1:0] line_up;
	logic signed [PIXEL_BITS-1:0] line_lo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1 <= emit_now;
			last_s1 <= last_now;
			pix_s1  <= pixel_value;
			addr_s1 <= col_q;
		end
	end

	assign line_up = line_rd[PIXEL_BITS-1:0];
	assign line_lo = line_rd[2*PIXEL_BITS-1:PIXEL_BITS];

	// each entry holds {row just above, row two above}; a column is rewritten in
	// the cycle after its read and read again no sooner than three pixels later
	c2d_ram #(
		.WIDTH(2 * PIXEL_BITS),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (valid_s1),
		.wr_addr (addr_s1),
		.wr_data ({pix_s1, line_lo}),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (line_rd)
	);

	// 3x3 window, row-major, column 2 newest
	logic signed [PIXEL_BITS-1:0] win_q [KERNEL_TAPS*KERNEL_TAPS];

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			for (int i = 0; i < KERNEL_TAPS; i++) begin
				win_q[i*KERNEL_TAPS]     <= win_q[i*KERNEL_TAPS + 1];
				win_q[i*KERNEL_TAPS + 1] <= win_q[i*KERNEL_TAPS + 2];
			end
			win_q[2] <= line_up;
			win_q[5] <= line_lo;
			win_q[8] <= pix_s1;
		end
	end

	// stage 2: window holds this item; multiply
	logic                        valid_s2;
	logic                        last_s2;
	logic signed [PROD_BITS-1:0] prod_c [KERNEL_TAPS*KERNEL_TAPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			last_s2 <= last_s1;
		end
	end

	always_comb begin
		for (int i = 0; i < KERNEL_TAPS; i++) begin
			for (int j = 0; j < KERNEL_TAPS; j++) begin
				prod_c[i*KERNEL_TAPS + j] = coef_at(krow_q[i], j) * win_q[i*KERNEL_TAPS + j];
			end
		end
	end

	// stage 3: products
	logic                        valid_s3;
	logic                        last_s3;
	logic signed [PROD_BITS-1:0] prod_s3 [KERNEL_TAPS*KERNEL_TAPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			last_s3 <= last_s2;
			for (int k = 0; k < KERNEL_TAPS*KERNEL_TAPS; k++) prod_s3[k] <= prod_c[k];
		end
	end

	// stage 4: row sums
	logic                        valid_s4;
	logic                        last_s4;
	logic signed [RSUM_BITS-1:0] rsum_s4 [KERNEL_TAPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			last_s4 <= last_s3;
			for (int i = 0; i < KERNEL_TAPS; i++) begin
				rsum_s4[i] <= RSUM_BITS'(prod_s3[i*KERNEL_TAPS])
					+ RSUM_BITS'(prod_s3[i*KERNEL_TAPS + 1])
					+ RSUM_BITS'(prod_s3[i*KERNEL_TAPS + 2]);
			end
		end
	end

	logic signed [ACC_BITS-1:0] acc;

	assign acc = ACC_BITS'(rsum_s4[0]) + ACC_BITS'(rsum_s4[1]) + ACC_BITS'(rsum_s4[2]);

	// output FIFO
	logic signed [SUM_BITS-1:0] fifo_sum_q [OUT_FIFO_DEPTH];
	logic                       fifo_end_q [OUT_FIFO_DEPTH];
	logic [FIFO_AW-1:0]         wr_ptr_q;
	logic [FIFO_AW-1:0]         rd_ptr_q;
	logic [CNT_BITS-1:0]        fill_q;

	assign out_valid = fill_q != '0;
	assign pop       = out_valid && out_ready;
	assign conv_sum  = fifo_sum_q[rd_ptr_q];
	assign frame_end = fifo_end_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (valid_s4) begin
			fifo_sum_q[wr_ptr_q] <= SUM_BITS'(acc);
			fifo_end_q[wr_ptr_q] <= last_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (valid_s4) wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			unique case ({valid_s4, pop})
				2'b10:   fill_q <= fill_q + CNT_BITS'(1);
				2'b01:   fill_q <= fill_q - CNT_BITS'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/c2d_checker.sv
`include "conv2d_3x3_valid_defines.svh"

module c2d_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                psel,
	input logic                                penable,
	input logic                                pwrite,
	input logic [c2d_pkg::CFG_ADDR_BITS-1:0]   paddr,
	input logic [c2d_pkg::CFG_DATA_BITS-1:0]   pwdata,
	input logic [c2d_pkg::CFG_DATA_BITS-1:0]   prdata,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [c2d_pkg::SUM_BITS-1:0] conv_sum,
	input logic                                frame_end
);

	import c2d_pkg::*;

	reg_idx_t idx;
	logic     cfg_wr;
	logic     cfg_rd;

	assign idx    = paddr[CFG_ADDR_BITS-1:CFG_ADDR_BITS-REG_IDX_BITS];
	assign cfg_wr = psel && penable && pwrite;
	assign cfg_rd = psel && !pwrite;

	// hold a stalled result
	`C2D_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`C2D_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(conv_sum) && $stable(frame_end), "stalled result changed")

	// a register reads back what was just written
	`C2D_ASSERT_NOW(a_width_readback, (cfg_wr && idx == REG_WIDTH) ##1 (cfg_rd && idx == REG_WIDTH), prdata[DIM_BITS-1:0] == $past(pwdata[DIM_BITS-1:0]), "image_width readback mismatch")
	`C2D_ASSERT_NOW(a_ktop_readback, (cfg_wr && idx == REG_KTOP) ##1 (cfg_rd && idx == REG_KTOP), prdata[KROW_BITS-1:0] == $past(pwdata[KROW_BITS-1:0]), "kernel_row_top readback mismatch")

endmodule

bind conv2d_3x3_valid c2d_checker u_c2d_checker (.*);
